FILE: rtl/core/scfk_pkg.sv
// ============================================================================
// scfk_pkg: shared types and constants of the serial command framer
// Holds the payload structs of both channels, the job descriptor that travels
// from the front end to the back end, and the character and kind codes.
// ============================================================================
package scfk_pkg;

    // Width of buffer positions and frame lengths; covers the largest buffer.
    localparam int POS_W = 7;
    // Width of the fixed frame byte countdown.
    localparam int REM_W = 5;

    localparam logic [15:0] PERIOD_RESET = 16'd250;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_ALARM = 2'd1;
    localparam logic [1:0] KIND_ECHO  = 2'd2;

    // Operation codes of an input transaction.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Characters with a meaning to the framer.
    localparam logic [7:0] CH_HEARTBEAT = 8'h7E;  // '~'
    localparam logic [7:0] CH_TEXT      = 8'h3C;  // '<'
    localparam logic [7:0] CH_FIXED     = 8'h2A;  // '*'
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;  // '\n'
    localparam logic [7:0] CH_RETURN    = 8'h5E;  // '^'

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        frame_kind;
        logic [7:0]  data;
        logic        last;
        logic [15:0] byte_sum;
        logic        emergency;
    } t_out_item;

    // One unit of work for the back end: a whole frame or a single result.
    typedef struct packed {
        logic [1:0]       kind;
        logic             frame_kind;
        logic [POS_W-1:0] len;
        logic [15:0]      byte_sum;
        logic [7:0]       data;
        logic             emergency;
    } t_job;

    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        logic [7:0]       data;
    } t_buf_wr;

endpackage

FILE: rtl/core/scfk_front.sv
// ============================================================================
// scfk_front: input classification and framing state
// Decodes bytes and ticks, keeps the frame and watchdog state, writes frame
// bytes into the buffer and hands finished work to the job queue.
// ============================================================================
module scfk_front
    import scfk_pkg::*;
#(
    parameter int BUF_DEPTH     = 32,
    parameter int FIXED_PAYLOAD = 6,
    parameter int STORE_DEPTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    input  logic        i_hold,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_push,
    output t_job        o_job,
    output t_buf_wr     o_buf_wr
);

    localparam int PW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_TEXT,
        MODE_FIXED
    } t_mode;

    t_mode            r_mode,   n_mode;
    logic [PW-1:0]    r_wpos,   n_wpos;
    logic [REM_W-1:0] r_remain, n_remain;
    logic [15:0]      r_sum,    n_sum;
    logic             r_stay,   n_stay;
    logic             r_alive,  n_alive;
    logic             r_emerg,  n_emerg;
    logic [15:0]      r_tick,   n_tick;
    logic             r_armed,  n_armed;
    logic [15:0]      r_period, n_period;

    logic             accept;
    logic [7:0]       b;
    logic [PW-1:0]    wpos_inc;
    logic [15:0]      sum_add;
    logic [REM_W-1:0] rem_dec;

    assign o_in_stall = i_hold;
    assign accept     = i_in_valid && !i_hold;
    assign b          = i_in_data.byte_value;
    assign wpos_inc   = r_wpos + PW'(1);
    assign sum_add    = r_sum + {8'd0, b};
    assign rem_dec    = (r_remain != '0) ? r_remain - REM_W'(1) : '0;

    always_comb begin
        n_mode   = r_mode;
        n_wpos   = r_wpos;
        n_remain = r_remain;
        n_sum    = r_sum;
        n_stay   = r_stay;
        n_alive  = r_alive;
        n_emerg  = r_emerg;
        n_tick   = r_tick;
        n_armed  = r_armed;
        n_period = i_cfg_we ? i_cfg_data : r_period;
        o_push   = 1'b0;
        o_job    = '0;
        o_buf_wr = '{en: 1'b0, addr: POS_W'(r_wpos), data: b};

        if (accept) begin
            if (i_in_data.operation == OP_TICK) begin
                if (r_armed) begin
                    if (r_tick > 16'd1) begin
                        n_tick = r_tick - 16'd1;
                    end else if (!r_stay && !r_alive) begin
                        n_emerg  = 1'b1;
                        n_armed  = 1'b0;
                        n_tick   = '0;
                        o_push   = 1'b1;
                        o_job    = '{kind: KIND_ALARM, frame_kind: 1'b0, len: '0,
                                     byte_sum: '0, data: '0, emergency: 1'b1};
                    end else begin
                        if (!r_stay) begin
                            n_alive = 1'b0;
                        end
                        n_tick = r_period;
                    end
                end
            end else if (r_emerg) begin
                if (b == CH_RETURN) begin
                    n_stay   = 1'b1;
                    n_alive  = 1'b1;
                    n_emerg  = 1'b0;
                    n_armed  = 1'b1;
                    n_tick   = r_period;
                    n_mode   = MODE_IDLE;
                    n_wpos   = '0;
                    n_remain = '0;
                    n_sum    = '0;
                    o_push   = 1'b1;
                    o_job    = '{kind: KIND_ECHO, frame_kind: 1'b0, len: '0,
                                 byte_sum: '0, data: b, emergency: 1'b0};
                end
            end else begin
                case (r_mode)
                    MODE_TEXT: begin
                        o_buf_wr.en = 1'b1;
                        n_wpos      = wpos_inc;
                        n_sum       = sum_add;
                        if (b == CH_NEWLINE) begin
                            o_push   = 1'b1;
                            o_job    = '{kind: KIND_BYTE, frame_kind: 1'b0,
                                         len: POS_W'(wpos_inc), byte_sum: sum_add,
                                         data: '0, emergency: 1'b0};
                            n_mode   = MODE_IDLE;
                            n_wpos   = '0;
                            n_sum    = '0;
                        end else if (wpos_inc > PW'(BUF_DEPTH - 2)) begin
                            // Overlong text frame: dropped without a result.
                            n_mode   = MODE_IDLE;
                            n_wpos   = '0;
                            n_sum    = '0;
                        end
                    end
                    MODE_FIXED: begin
                        o_buf_wr.en = 1'b1;
                        n_wpos      = wpos_inc;
                        n_sum       = sum_add;
                        n_remain    = rem_dec;
                        if (rem_dec == '0) begin
                            o_push   = 1'b1;
                            o_job    = '{kind: KIND_BYTE, frame_kind: 1'b1,
                                         len: POS_W'(wpos_inc), byte_sum: '0,
                                         data: '0, emergency: 1'b0};
                            n_mode   = MODE_IDLE;
                            n_wpos   = '0;
                            n_sum    = '0;
                        end
                    end
                    default: begin
                        if (b == CH_HEARTBEAT) begin
                            n_stay  = 1'b0;
                            n_alive = 1'b1;
                        end else if (b == CH_TEXT || b == CH_FIXED) begin
                            // The opening character is the first frame byte.
                            o_buf_wr.en   = 1'b1;
                            o_buf_wr.addr = '0;
                            n_wpos        = PW'(1);
                            n_sum         = {8'd0, b};
                            if (b == CH_TEXT) begin
                                n_mode   = MODE_TEXT;
                                n_remain = '0;
                            end else begin
                                n_mode   = MODE_FIXED;
                                n_remain = REM_W'(FIXED_PAYLOAD);
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_wpos   <= '0;
            r_remain <= '0;
            r_sum    <= '0;
            r_stay   <= 1'b1;
            r_alive  <= 1'b1;
            r_emerg  <= 1'b0;
            r_tick   <= PERIOD_RESET;
            r_armed  <= 1'b1;
            r_period <= PERIOD_RESET;
        end else begin
            r_mode   <= n_mode;
            r_wpos   <= n_wpos;
            r_remain <= n_remain;
            r_sum    <= n_sum;
            r_stay   <= n_stay;
            r_alive  <= n_alive;
            r_emerg  <= n_emerg;
            r_tick   <= n_tick;
            r_armed  <= n_armed;
            r_period <= n_period;
        end
    end

endmodule

FILE: rtl/core/scfk_queue.sv
// ============================================================================
// scfk_queue: two-entry job queue
// Decouples the front end from the back end and reports whether a frame job
// is still waiting, since the frame buffer is shared between the two.
// ============================================================================
module scfk_queue
    import scfk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head,
    output logic o_full,
    output logic o_has_frame
);

    t_job r_ent [2];
    logic r_vld [2];
    logic r_rd;
    logic r_wr;

    assign o_valid     = r_vld[r_rd];
    assign o_head      = r_ent[r_rd];
    assign o_full      = r_vld[0] && r_vld[1];
    assign o_has_frame = (r_vld[0] && r_ent[0].kind == KIND_BYTE) ||
                         (r_vld[1] && r_ent[1].kind == KIND_BYTE);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
            r_rd     <= 1'b0;
            r_wr     <= 1'b0;
        end else begin
            if (i_pop) begin
                r_vld[r_rd] <= 1'b0;
                r_rd        <= ~r_rd;
            end
            if (i_push) begin
                r_vld[r_wr] <= 1'b1;
                r_wr        <= ~r_wr;
            end
        end
    end

endmodule

FILE: rtl/core/scfk_back.sv
// ============================================================================
// scfk_back: result sequencer with frame buffer
// Holds the frame buffer, turns each job into output transactions, one frame
// byte per cycle unless the output stalls, through a registered output stage.
// ============================================================================
module scfk_back
    import scfk_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_buf_wr   i_buf_wr,
    input  logic      i_q_valid,
    input  t_job      i_q_head,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic {
        BK_IDLE,
        BK_FRAME
    } t_bk_state;

    t_bk_state        r_state;
    t_job             r_job;
    logic [POS_W-1:0] r_idx, n_idx;
    logic [7:0]       r_rdata;
    logic [7:0]       r_mem [STORE_DEPTH];
    logic             r_out_valid;
    t_out_item        r_out;

    logic             out_free;
    logic             out_load;
    logic             frame_last;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign frame_last  = (r_idx + POS_W'(1)) == r_job.len;
    assign o_pop       = (r_state == BK_IDLE) && i_q_valid &&
                         (i_q_head.kind == KIND_BYTE || out_free);
    // A new result enters the output register in this cycle.
    assign out_load    = (r_state == BK_IDLE) ? (o_pop && i_q_head.kind != KIND_BYTE)
                                              : out_free;
    assign o_busy      = (r_state == BK_FRAME);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Read address runs one step ahead so r_rdata always holds entry r_idx.
    always_comb begin
        n_idx = r_idx;
        if (r_state == BK_IDLE) begin
            n_idx = '0;
        end else if (out_free) begin
            n_idx = frame_last ? '0 : r_idx + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_mem[i_buf_wr.addr[AW-1:0]] <= i_buf_wr.data;
        end
        r_rdata <= r_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                BK_IDLE: begin
                    if (o_pop) begin
                        if (i_q_head.kind == KIND_BYTE) begin
                            r_job   <= i_q_head;
                            r_state <= BK_FRAME;
                        end else begin
                            r_out       <= '{kind: i_q_head.kind, frame_kind: 1'b0,
                                             data: i_q_head.data, last: 1'b1,
                                             byte_sum: '0,
                                             emergency: i_q_head.emergency};
                        end
                    end
                end
                BK_FRAME: begin
                    if (out_free) begin
                        r_out       <= '{kind: KIND_BYTE, frame_kind: r_job.frame_kind,
                                         data: r_rdata, last: frame_last,
                                         byte_sum: frame_last ? r_job.byte_sum : '0,
                                         emergency: r_job.emergency};
                        if (frame_last) begin
                            r_state <= BK_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/serial_command_framer_keepalive_unit.sv
// ============================================================================
// serial_command_framer_keepalive_unit: serial command framer with watchdog
// Frames text and fixed commands out of received bytes, supervises a
// keep-alive heartbeat with timer ticks and reports alarms and returns.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall   t_in_item  (byte or tick)
//  out       source     o_out_valid / i_out_stall t_out_item (frame byte, alarm,
//                                                             echo)
//  cfg       sink       i_cfg_we                  keep-alive period, 16 bits
//
//  Bytes and ticks are decoded in the cycle they are accepted, one per cycle
//  unless stalled. An item that completes an N-byte frame yields N output
//  transactions, one per cycle from the buffer read port, by way of the queue;
//  the input stalls until the last byte is registered, and output stalls
//  stretch the drain. Alarms and echoes pass the queue and output register; a
//  full queue stalls input. Reset is synchronous, active low, buffer kept.
//
// The design has three parts. The front end decodes every transaction, keeps
// the frame, heartbeat and watchdog state and writes frame bytes into the
// buffer. Finished work goes into a short job queue as a descriptor: a whole
// frame (length and byte sum) or a single alarm or echo result. The back end
// owns the frame buffer and replays a frame byte by byte from it, or emits the
// single result, through a registered output stage, so a stalled output holds
// the front end only while a frame is pending or the queue is full.
//
module serial_command_framer_keepalive_unit
    import scfk_pkg::*;
#(
    parameter int BUF_DEPTH     = 32,
    parameter int FIXED_PAYLOAD = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    // The buffer must hold the longest text frame and a whole fixed frame.
    localparam int STORE_DEPTH = (BUF_DEPTH > FIXED_PAYLOAD + 1) ?
                                 BUF_DEPTH : FIXED_PAYLOAD + 1;

    logic    push;
    t_job    job;
    t_buf_wr buf_wr;
    logic    q_valid;
    t_job    q_head;
    logic    q_full;
    logic    q_has_frame;
    logic    pop;
    logic    back_busy;
    logic    hold;

    // Input waits while the queue is full or the buffer still holds a frame
    // that has not been fully sent.
    assign hold = q_full || q_has_frame || back_busy;

    scfk_front #(
        .BUF_DEPTH     (BUF_DEPTH),
        .FIXED_PAYLOAD (FIXED_PAYLOAD),
        .STORE_DEPTH   (STORE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_hold     (hold),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_job      (job),
        .o_buf_wr   (buf_wr)
    );

    scfk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (job),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .o_full      (q_full),
        .o_has_frame (q_has_frame)
    );

    scfk_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_buf_wr    (buf_wr),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    // The buffer is never written while the back end replays a frame from it.
    a_no_write_while_draining: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        buf_wr.en |-> !back_busy && !q_has_frame
    ) else $error("frame buffer written while a frame is pending");

    // The front end never pushes into a full queue.
    a_no_queue_overflow: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full
    ) else $error("job queue overflow");

    // An alarm always reports the emergency flag as set, an echo as cleared.
    a_alarm_flag: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_ALARM || o_out_data.kind == KIND_ECHO)
        |-> (o_out_data.emergency == (o_out_data.kind == KIND_ALARM)) && o_out_data.last
    ) else $error("alarm or echo result malformed");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for serial_command_framer_keepalive_unit
// Drives received bytes and timer ticks through the input channel and checks
// every output transaction against a behavioral predictor of the framer. The
// bench keeps its own copy of the frame and watchdog state. A directed table
// comes first, then phases of random traffic, each phase under its own
// keep-alive period. Both sides idle and stall at random.
// ============================================================================
module testbench;
    import scfk_pkg::*;

    localparam int FRAME_DEPTH   = 32;
    localparam int FIXED_LEN     = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 10;
    localparam int NUM_PHASES    = 5;
    localparam int CYCLE_LIMIT   = 4_000_000;

    typedef enum logic [1:0] {FRAME_IDLE, FRAME_TEXT, FRAME_FIXED} t_frame_mode;

    // One row of the directed table. When typed is set, the expected outcome
    // is written into the row: no result at all, or the single result given.
    typedef struct {
        t_in_item  item;
        int        reps;
        bit        typed;
        int        n_typed;
        t_out_item typed_res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        i_out_stall;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    serial_command_framer_keepalive_unit #(
        .BUF_DEPTH     (FRAME_DEPTH),
        .FIXED_PAYLOAD (FIXED_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: the bench's own copy of the framer and the watchdog.
    // ------------------------------------------------------------------------
    logic [7:0]  frame_store [0:FRAME_DEPTH-1];
    int          store_pos;
    t_frame_mode frame_mode;
    logic [4:0]  fixed_left;
    logic [15:0] sum_acc;
    bit          hb_stay;
    bit          hb_alive;
    bit          in_emergency;
    logic [15:0] tick_left;
    bit          watchdog_armed;
    logic [15:0] period_reg;

    t_out_item   step_results [$];     // results of the transaction just accepted
    t_out_item   awaited_results [$];  // results not yet seen on the output
    t_stim_row   stim_rows [$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;       // no idling on either side while set
    bit  hold_req = 1'b0;   // asks the output side for one long hold-off

    function automatic t_out_item make_result(logic [1:0] kind, logic fk, logic [7:0] data,
                                              logic last, logic [15:0] sum, logic emerg);
        t_out_item r;
        r.kind       = kind;
        r.frame_kind = fk;
        r.data       = data;
        r.last       = last;
        r.byte_sum   = sum;
        r.emergency  = emerg;
        return r;
    endfunction

    // Short gaps most of the time, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic clear_frame_state();
        store_pos  = 0;
        frame_mode = FRAME_IDLE;
        fixed_left = '0;
        sum_acc    = '0;
    endtask

    task automatic framer_reset();
        clear_frame_state();
        hb_stay        = 1'b1;
        hb_alive       = 1'b1;
        in_emergency   = 1'b0;
        period_reg     = PERIOD_RESET;
        tick_left      = PERIOD_RESET;
        watchdog_armed = 1'b1;
    endtask

    task automatic store_frame_byte(logic [7:0] b);
        if (store_pos < FRAME_DEPTH) begin
            frame_store[store_pos] = b;
            store_pos++;
        end
        sum_acc = sum_acc + 16'(b);
    endtask

    // A finished frame comes out byte by byte; only a text frame carries the
    // byte sum, and only on its final byte.
    task automatic emit_frame();
        logic fk;
        bit   fin;
        fk = (frame_mode == FRAME_FIXED);
        for (int i = 0; i < store_pos; i++) begin
            fin = (i + 1 == store_pos);
            step_results.push_back(make_result(KIND_BYTE, fk, frame_store[i], fin,
                                               (fin && !fk) ? sum_acc : 16'h0,
                                               in_emergency));
        end
        clear_frame_state();
    endtask

    task automatic predict_tick();
        if (!watchdog_armed)
            return;
        if (tick_left > 16'd1) begin
            tick_left--;
            return;
        end
        // Period expired: two checks in a row without a heartbeat raise the alarm.
        if (!hb_stay && !hb_alive) begin
            in_emergency   = 1'b1;
            watchdog_armed = 1'b0;
            tick_left      = '0;
            step_results.push_back(make_result(KIND_ALARM, 1'b0, 8'h00, 1'b1, 16'h0, 1'b1));
            return;
        end
        if (!hb_stay)
            hb_alive = 1'b0;
        tick_left = period_reg;
    endtask

    task automatic predict_byte(logic [7:0] b);
        if (in_emergency) begin
            if (b != CH_RETURN)
                return;
            hb_stay        = 1'b1;
            hb_alive       = 1'b1;
            in_emergency   = 1'b0;
            clear_frame_state();
            watchdog_armed = 1'b1;
            tick_left      = period_reg;
            step_results.push_back(make_result(KIND_ECHO, 1'b0, b, 1'b1, 16'h0, 1'b0));
            return;
        end
        case (frame_mode)
            FRAME_TEXT: begin
                store_frame_byte(b);
                if (b == CH_NEWLINE)
                    emit_frame();
                else if (store_pos > FRAME_DEPTH - 2)
                    clear_frame_state();  // too long: dropped without a trace
            end
            FRAME_FIXED: begin
                store_frame_byte(b);
                if (fixed_left != 0)
                    fixed_left--;
                if (fixed_left == 0)
                    emit_frame();
            end
            default: begin
                if (b == CH_HEARTBEAT) begin
                    hb_stay  = 1'b0;
                    hb_alive = 1'b1;
                end else if (b == CH_TEXT) begin
                    clear_frame_state();
                    frame_mode = FRAME_TEXT;
                    store_frame_byte(b);
                end else if (b == CH_FIXED) begin
                    clear_frame_state();
                    frame_mode = FRAME_FIXED;
                    fixed_left = 5'(FIXED_LEN);
                    store_frame_byte(b);
                    if (fixed_left == 0)
                        emit_frame();
                end
            end
        endcase
    endtask

    task automatic framer_predict(t_in_item it);
        step_results.delete();
        if (it.operation == OP_TICK)
            predict_tick();
        else
            predict_byte(it.byte_value);
    endtask

    // ------------------------------------------------------------------------
    // Input side. Each call offers one transaction, optionally after an idle
    // gap, and returns at the edge where it was accepted. Valid stays high
    // between back-to-back transactions.
    // ------------------------------------------------------------------------
    task automatic offer_item(t_in_item it, bit use_model);
        int gap;
        if (!calm && $urandom_range(0, 99) < 25) begin
            gap = pick_gap();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        framer_predict(it);
        if (use_model)
            foreach (step_results[i])
                awaited_results.push_back(step_results[i]);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it.operation  = OP_BYTE;
        it.byte_value = b;
        offer_item(it, 1'b1);
    endtask

    task automatic send_tick();
        t_in_item it;
        it.operation  = OP_TICK;
        it.byte_value = 8'($urandom_range(0, 255));  // ignored by the block
        offer_item(it, 1'b1);
    endtask

    // Stops offering and waits until every awaited result has come, then lets
    // the pipeline run dry of transactions that cause no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        period_reg = v;  // a running count keeps going; the new value loads at rearm
    endtask

    task automatic add_row(logic op, logic [7:0] b, int reps, bit typed, int n_typed,
                           t_out_item res);
        t_stim_row row;
        row.item.operation  = op;
        row.item.byte_value = b;
        row.reps            = reps;
        row.typed           = typed;
        row.n_typed         = n_typed;
        row.typed_res       = res;
        stim_rows.push_back(row);
    endtask

    // One random sequence: mostly well-formed frames and heartbeats with random
    // content, some tick bursts, returns and plain noise.
    task automatic send_random_sequence();
        int sel;
        int len;
        int r;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            send_byte(CH_HEARTBEAT);
        end else if (sel < 32) begin
            len = $urandom_range(1, 4);
            repeat (len) send_tick();
        end else if (sel < 55) begin
            // Text frame: usually short, sometimes right up to the buffer
            // limit, sometimes long enough to be dropped.
            r = $urandom_range(0, 9);
            if (r < 6)
                len = $urandom_range(0, 6);
            else if (r < 8)
                len = $urandom_range(7, FRAME_DEPTH - 3);
            else
                len = $urandom_range(FRAME_DEPTH - 2, FRAME_DEPTH + 2);
            send_byte(CH_TEXT);
            repeat (len) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
                send_byte(b);
            end
            if (len <= FRAME_DEPTH - 3)
                send_byte(CH_NEWLINE);
        end else if (sel < 75) begin
            send_byte(CH_FIXED);
            repeat (FIXED_LEN) send_byte(8'($urandom_range(0, 255)));
        end else if (sel < 83) begin
            send_byte(CH_RETURN);
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off on request so that the
    // block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : out_stall_gen
        int stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_left = 0;
            end else begin
                if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15)
                    stall_left = pick_gap();
                i_out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Every accepted output transaction is matched against the oldest
    // awaited result.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d data %0h", o_out_data.kind,
                       o_out_data.data);
                fail_count++;
            end else begin
                exp_r = awaited_results.pop_front();
                check_field("kind", 16'(exp_r.kind), 16'(o_out_data.kind));
                check_field("frame_kind", 16'(exp_r.frame_kind), 16'(o_out_data.frame_kind));
                check_field("data", 16'(exp_r.data), 16'(o_out_data.data));
                check_field("last", 16'(exp_r.last), 16'(o_out_data.last));
                check_field("byte_sum", exp_r.byte_sum, o_out_data.byte_sum);
                check_field("emergency", 16'(exp_r.emergency), 16'(o_out_data.emergency));
            end
        end
    end

    initial begin : watchdog_limit
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_out_item   none;
        t_out_item   alarm_res;
        t_out_item   echo_res;
        logic [15:0] phase_period [NUM_PHASES];
        int          phase_start;
        bit          paused;

        none       = '0;
        alarm_res  = make_result(KIND_ALARM, 1'b0, 8'h00, 1'b1, 16'h0, 1'b1);
        echo_res   = make_result(KIND_ECHO, 1'b0, CH_RETURN, 1'b1, 16'h0, 1'b0);
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        framer_reset();
        repeat (4) @(posedge i_clk);

        // A short period for the directed part; the count already running
        // from reset still finishes at the reset value first.
        write_period(16'd2);

        // These ticks bring the reset count down to one and the next one runs
        // it out; the heartbeat flags are still set from reset, so it only
        // rearms.
        add_row(OP_TICK, 8'h00, int'(PERIOD_RESET) - 1, 1'b1, 0, none);
        add_row(OP_TICK, 8'hFF, 1, 1'b1, 0, none);
        add_row(OP_BYTE, CH_HEARTBEAT, 1, 1'b1, 0, none);
        // Bytes with no meaning while idle are ignored.
        add_row(OP_BYTE, 8'h41, 1, 1'b1, 0, none);
        add_row(OP_BYTE, 8'h00, 1, 1'b1, 0, none);
        add_row(OP_BYTE, 8'hFF, 1, 1'b1, 0, none);
        add_row(OP_BYTE, CH_RETURN, 1, 1'b1, 0, none);
        add_row(OP_BYTE, CH_NEWLINE, 1, 1'b1, 0, none);
        // Text frame holding the byte extremes.
        add_row(OP_BYTE, CH_TEXT, 1, 1'b0, 0, none);
        add_row(OP_BYTE, 8'h00, 1, 1'b0, 0, none);
        add_row(OP_BYTE, 8'hFF, 1, 1'b0, 0, none);
        add_row(OP_BYTE, CH_NEWLINE, 1, 1'b0, 0, none);
        // Fixed frame: a newline inside it is payload, not an end marker.
        add_row(OP_BYTE, CH_FIXED, 1, 1'b0, 0, none);
        add_row(OP_BYTE, CH_NEWLINE, 1, 1'b0, 0, none);
        add_row(OP_BYTE, 8'hFF, 1, 1'b0, 0, none);
        add_row(OP_BYTE, 8'h00, 1, 1'b0, 0, none);
        add_row(OP_BYTE, CH_TEXT, 1, 1'b0, 0, none);
        add_row(OP_BYTE, CH_HEARTBEAT, 1, 1'b0, 0, none);
        add_row(OP_BYTE, CH_RETURN, 1, 1'b0, 0, none);
        // Longest text frame: the newline lands on the last slot a text frame may use.
        add_row(OP_BYTE, CH_TEXT, 1, 1'b0, 0, none);
        add_row(OP_BYTE, 8'hA5, FRAME_DEPTH - 3, 1'b0, 0, none);
        add_row(OP_BYTE, CH_NEWLINE, 1, 1'b0, 0, none);
        // One byte more and the frame is dropped; the newline then is ignored.
        add_row(OP_BYTE, CH_TEXT, 1, 1'b1, 0, none);
        add_row(OP_BYTE, 8'h5A, FRAME_DEPTH - 2, 1'b1, 0, none);
        add_row(OP_BYTE, CH_NEWLINE, 1, 1'b1, 0, none);
        // The heartbeat above cleared stay: the next expiry clears alive and
        // the one after raises the alarm.
        add_row(OP_TICK, 8'h00, 3, 1'b1, 0, none);
        add_row(OP_TICK, 8'h00, 1, 1'b1, 1, alarm_res);
        // In an emergency ticks and any byte but the return are ignored.
        add_row(OP_TICK, 8'h00, 2, 1'b1, 0, none);
        add_row(OP_BYTE, CH_TEXT, 1, 1'b1, 0, none);
        add_row(OP_BYTE, CH_HEARTBEAT, 1, 1'b1, 0, none);
        add_row(OP_BYTE, CH_RETURN, 1, 1'b1, 1, echo_res);

        foreach (stim_rows[i]) begin
            repeat (stim_rows[i].reps) begin
                offer_item(stim_rows[i].item, !stim_rows[i].typed);
                if (stim_rows[i].typed && stim_rows[i].n_typed == 1)
                    awaited_results.push_back(stim_rows[i].typed_res);
            end
        end

        // Random phases, each under its own period: shortest, a few ticks,
        // longest, zero (acts as one tick) and a random short one.
        phase_period[0] = 16'd1;
        phase_period[1] = 16'd3;
        phase_period[2] = 16'hFFFF;
        phase_period[3] = 16'd0;
        phase_period[4] = 16'($urandom_range(2, 6));

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_period(phase_period[p]);
            calm = (p == 3);
            if (p == 2)
                hold_req = 1'b1;  // sender keeps offering while output is held off
            phase_start = items_sent;
            paused = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_random_sequence();
                if (p == 1 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
                    // Sender pause until every awaited result has come out.
                    paused = 1'b1;
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (awaited_results.size() != 0);
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
